// File: src/gnpp_pkg.sv
// Package for the gated nearest path point unit.
// Holds the shared types, codes and sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gnpp_pkg;

  // Path length limit and the widths derived from it.
  localparam int MaxPoints = 1024;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = IdxW + 1;

  // Field widths of the ports.
  localparam int PosW      = 24;
  localparam int YawW      = 16;
  localparam int OutIdxW   = 10;
  localparam int OutDsqW   = 49;
  localparam int DistGateW = 23;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 23;

  // Internal arithmetic widths.
  localparam int DiffW     = PosW + 1;        // magnitude of a coordinate difference
  localparam int SqW       = 2 * PosW + 1;    // one squared difference
  localparam int DsqW      = SqW + 1;         // sum of two squares
  localparam int ThrSqW    = 2 * DistGateW;   // squared distance gate
  localparam int MagW      = YawW + 1;        // magnitude of a wrapped yaw difference

  // Input opcodes.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_POINT  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DIST_GATE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_YAW_GATE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_EN  = 2'd2;

  // Configuration reset values.
  localparam logic [DistGateW-1:0] DIST_GATE_RST = 23'd1280;
  localparam logic [YawW-1:0]      YAW_GATE_RST  = 16'd8192;

  // Kind of work that travels from front to back.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_POINT,
    KIND_FINISH
  } kind_e;

  // Configuration seen by both halves.
  typedef struct packed {
    logic [DistGateW-1:0] dist_gate;
    logic [YawW-1:0]      yaw_gate;
    logic                 angle_en;
  } cfg_t;

  // One queue entry, already classified by the front.
  typedef struct packed {
    kind_e              kind;
    logic [OutIdxW-1:0] idx;
    logic [DiffW-1:0]   adx;
    logic [DiffW-1:0]   ady;
    logic               ang_ok;
  } work_t;

  // Queue depth.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

endpackage

`default_nettype wire

// File: src/gnpp_queue.sv
// Short queue of classified work between front and back.
// Depends on gnpp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module gnpp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gnpp_pkg::work_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output gnpp_pkg::work_t      head_o
);

  gnpp_pkg::work_t                mem_q [gnpp_pkg::QDepth];
  logic [gnpp_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [gnpp_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [gnpp_pkg::QCntW-1:0]     count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == gnpp_pkg::QCntW'(gnpp_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/gnpp_front.sv
// Front half: accepts input transfers, holds the query and point count,
// and turns each item into classified work. Depends on gnpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gnpp_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gnpp_pkg::cfg_t                cfg_i,
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic signed [gnpp_pkg::PosW-1:0] pos_x_i,
  input  wire logic signed [gnpp_pkg::PosW-1:0] pos_y_i,
  input  wire logic [gnpp_pkg::YawW-1:0]     yaw_i,
  output logic                               push_o,
  output gnpp_pkg::work_t                    work_o
);

  logic signed [gnpp_pkg::PosW-1:0]  query_x_q, query_x_d;
  logic signed [gnpp_pkg::PosW-1:0]  query_y_q, query_y_d;
  logic [gnpp_pkg::YawW-1:0]         query_yaw_q, query_yaw_d;
  logic [gnpp_pkg::CntW-1:0]         count_q, count_d;

  logic signed [gnpp_pkg::DiffW-1:0] dx, dy;
  logic [gnpp_pkg::DiffW-1:0]        adx, ady;
  logic [gnpp_pkg::YawW-1:0]         heading_delta;
  logic [gnpp_pkg::MagW-1:0]         yaw_mag;
  logic                              ang_ok;
  logic                              room;

  // Coordinate differences as magnitudes.
  always_comb begin
    dx  = gnpp_pkg::DiffW'(pos_x_i) - gnpp_pkg::DiffW'(query_x_q);
    dy  = gnpp_pkg::DiffW'(pos_y_i) - gnpp_pkg::DiffW'(query_y_q);
    adx = dx[gnpp_pkg::DiffW-1] ? gnpp_pkg::DiffW'(-dx) : gnpp_pkg::DiffW'(dx);
    ady = dy[gnpp_pkg::DiffW-1] ? gnpp_pkg::DiffW'(-dy) : gnpp_pkg::DiffW'(dy);
  end

  // Heading gate: the binary angle difference wraps on its own.
  always_comb begin
    heading_delta = query_yaw_q - yaw_i;
    yaw_mag       = heading_delta[gnpp_pkg::YawW-1]
                  ? (gnpp_pkg::MagW'(1) << gnpp_pkg::YawW) - {1'b0, heading_delta}
                  : {1'b0, heading_delta};
    ang_ok        = !cfg_i.angle_en || (yaw_mag <= {1'b0, cfg_i.yaw_gate});
  end

  assign room = (count_q < gnpp_pkg::CntW'(gnpp_pkg::MaxPoints));

  // Classification; unused opcodes and points past the limit are dropped.
  always_comb begin
    push_o        = 1'b0;
    work_o.kind   = gnpp_pkg::KIND_START;
    work_o.idx    = gnpp_pkg::OutIdxW'(count_q);
    work_o.adx    = adx;
    work_o.ady    = ady;
    work_o.ang_ok = ang_ok;
    query_x_d     = query_x_q;
    query_y_d     = query_y_q;
    query_yaw_d   = query_yaw_q;
    count_d       = count_q;
    if (accept_i) begin
      unique case (opcode_i)
        gnpp_pkg::OP_START: begin
          push_o      = 1'b1;
          work_o.kind = gnpp_pkg::KIND_START;
          query_x_d   = pos_x_i;
          query_y_d   = pos_y_i;
          query_yaw_d = yaw_i;
          count_d     = '0;
        end
        gnpp_pkg::OP_POINT: begin
          push_o      = room;
          work_o.kind = gnpp_pkg::KIND_POINT;
          if (room) begin
            count_d = count_q + 1'b1;
          end
        end
        gnpp_pkg::OP_FINISH: begin
          push_o      = 1'b1;
          work_o.kind = gnpp_pkg::KIND_FINISH;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q   <= '0;
      query_y_q   <= '0;
      query_yaw_q <= '0;
      count_q     <= '0;
    end else begin
      query_x_q   <= query_x_d;
      query_y_q   <= query_y_d;
      query_yaw_q <= query_yaw_d;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: src/gnpp_back.sv
// Back half: squares, gates and compares each point, keeps the best one
// and drives the result register. Depends on gnpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gnpp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gnpp_pkg::cfg_t              cfg_i,
  input  wire logic                        empty_i,
  input  wire gnpp_pkg::work_t             head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             found_o,
  output logic [gnpp_pkg::OutIdxW-1:0]     best_index_o,
  output logic [gnpp_pkg::OutDsqW-1:0]     best_dist_sq_o
);

  logic                              advance;

  // Squared gate, recomputed from the register every cycle.
  logic [gnpp_pkg::ThrSqW-1:0]       thr_sq_q;

  // Stage A: squares.
  logic                              a_valid_q;
  gnpp_pkg::kind_e                   a_kind_q;
  logic [gnpp_pkg::OutIdxW-1:0]      a_idx_q;
  logic                              a_ang_ok_q;
  logic [gnpp_pkg::SqW-1:0]          a_sqx_q, a_sqy_q;

  // Stage B: sum and gate.
  logic                              b_valid_q;
  gnpp_pkg::kind_e                   b_kind_q;
  logic [gnpp_pkg::OutIdxW-1:0]      b_idx_q;
  logic                              b_pass_q;
  logic [gnpp_pkg::DsqW-1:0]         b_dsq_q;
  logic [gnpp_pkg::DsqW-1:0]         dsq_sum;

  // Best point so far.
  logic                              best_found_q, best_found_d;
  logic [gnpp_pkg::OutIdxW-1:0]      best_idx_q, best_idx_d;
  logic [gnpp_pkg::DsqW-1:0]         best_dsq_q, best_dsq_d;

  // Result register.
  logic                              out_valid_q, out_valid_d;
  logic                              out_found_q;
  logic [gnpp_pkg::OutIdxW-1:0]      out_idx_q;
  logic [gnpp_pkg::OutDsqW-1:0]      out_dsq_q;
  logic                              out_load;

  // The whole back pipeline moves unless a result waits on a stalled receiver.
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !empty_i;

  always_ff @(posedge clk_i) begin
    thr_sq_q <= gnpp_pkg::ThrSqW'(cfg_i.dist_gate * cfg_i.dist_gate);
  end

  // Stage A and stage B valid control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= !empty_i;
      b_valid_q <= a_valid_q;
    end
  end

  // Stage A payload: one multiplier per axis.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_kind_q   <= head_i.kind;
      a_idx_q    <= head_i.idx;
      a_ang_ok_q <= head_i.ang_ok;
      a_sqx_q    <= gnpp_pkg::SqW'(head_i.adx * head_i.adx);
      a_sqy_q    <= gnpp_pkg::SqW'(head_i.ady * head_i.ady);
    end
  end

  assign dsq_sum = gnpp_pkg::DsqW'(a_sqx_q) + gnpp_pkg::DsqW'(a_sqy_q);

  // Stage B payload: the distance gate.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_kind_q <= a_kind_q;
      b_idx_q  <= a_idx_q;
      b_dsq_q  <= dsq_sum;
      b_pass_q <= a_ang_ok_q && (dsq_sum <= gnpp_pkg::DsqW'(thr_sq_q));
    end
  end

  // Best tracking and result load; an earlier index keeps a tie.
  always_comb begin
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_dsq_d   = best_dsq_q;
    out_load     = 1'b0;
    if (advance && b_valid_q) begin
      unique case (b_kind_q)
        gnpp_pkg::KIND_START: begin
          best_found_d = 1'b0;
          best_idx_d   = '0;
          best_dsq_d   = '0;
        end
        gnpp_pkg::KIND_POINT: begin
          if (b_pass_q && (!best_found_q || (b_dsq_q < best_dsq_q))) begin
            best_found_d = 1'b1;
            best_idx_d   = b_idx_q;
            best_dsq_d   = b_dsq_q;
          end
        end
        gnpp_pkg::KIND_FINISH: begin
          out_load = 1'b1;
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end
  end

  // A result leaves on a transfer; a finish fills the register again.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = out_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_dsq_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      best_found_q <= best_found_d;
      best_idx_q   <= best_idx_d;
      best_dsq_q   <= best_dsq_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= best_found_q;
      out_idx_q   <= best_idx_q;
      out_dsq_q   <= gnpp_pkg::OutDsqW'(best_dsq_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign best_index_o   = out_idx_q;
  assign best_dist_sq_o = out_dsq_q;

endmodule

`default_nettype wire

// File: src/gated_nearest_path_point_unit.sv
// Top level of the gated nearest path point unit: configuration registers,
// front half, work queue and back half. Depends on gnpp_pkg and its modules.
//
// Usage: a start item (opcode 0) loads the query pose and clears the search,
// each point item (opcode 1) is one path point in order, and a finish item
// (opcode 2) produces one result transfer with found, best_index and
// best_dist_sq. Opcode 3 and points past the path length limit are dropped.
// The input channel takes one transfer per cycle while the four-entry work
// queue has room; in_stall_o rises only when that queue is full.
// The back half squares, gates and compares one point per cycle while no result
// waits under out_stall_i, so the sustained rate is one item per clock. An accepted
// finish passes through the work queue, stage A, stage B and the result register.
// While a result waits under out_stall_i the back half holds; the front keeps
// accepting until the queue fills. Reset clears the query, the count, the
// best point and all valid flags, and restores the register reset values.
// Configuration registers load at the write edge. The user must write them only
// while nothing is in flight (no result waiting, queue empty, then two idle cycles
// so that the two back stages drain); the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module gated_nearest_path_point_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [gnpp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [gnpp_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic signed [gnpp_pkg::PosW-1:0]  pos_x_i,
  input  wire logic signed [gnpp_pkg::PosW-1:0]  pos_y_i,
  input  wire logic [gnpp_pkg::YawW-1:0]         yaw_i,
  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   found_o,
  output logic [gnpp_pkg::OutIdxW-1:0]           best_index_o,
  output logic [gnpp_pkg::OutDsqW-1:0]           best_dist_sq_o
);

  gnpp_pkg::cfg_t  cfg_q, cfg_d;
  gnpp_pkg::work_t push_work, head_work;
  logic            push, q_full, q_empty, pop;
  logic            in_accept;

  // Configuration registers; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        gnpp_pkg::CFG_DIST_GATE: cfg_d.dist_gate = cfg_wdata_i[gnpp_pkg::DistGateW-1:0];
        gnpp_pkg::CFG_YAW_GATE:  cfg_d.yaw_gate  = cfg_wdata_i[gnpp_pkg::YawW-1:0];
        gnpp_pkg::CFG_ANGLE_EN:  cfg_d.angle_en  = cfg_wdata_i[0];
        default:                 cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_gate <= gnpp_pkg::DIST_GATE_RST;
      cfg_q.yaw_gate  <= gnpp_pkg::YAW_GATE_RST;
      cfg_q.angle_en  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input transfer handshake.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  gnpp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_accept),
    .opcode_i (opcode_i),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .yaw_i    (yaw_i),
    .push_o   (push),
    .work_o   (push_work)
  );

  gnpp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_work),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_work)
  );

  gnpp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .empty_i        (q_empty),
    .head_i         (head_work),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .best_index_o   (best_index_o),
    .best_dist_sq_o (best_dist_sq_o)
  );

endmodule

`default_nettype wire

// File: verif/tb_gated_nearest_path_point_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for gated_nearest_path_point_unit. It drives start, point and
// finish transfers with random gaps and stalls, and compares every result with a search
// predictor kept inside the testbench. Depends on gnpp_pkg and the unit's RTL only.

module tb_gated_nearest_path_point_unit;
  import gnpp_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0]         OP_UNUSED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 425;

  typedef struct packed {
    logic               found;
    logic [OutIdxW-1:0] idx;
    logic [OutDsqW-1:0] dsq;
  } search_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                opcode_i = '0;
  logic signed [PosW-1:0]    pos_x_i = '0;
  logic signed [PosW-1:0]    pos_y_i = '0;
  logic [YawW-1:0]           yaw_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      found_o;
  logic [OutIdxW-1:0]        best_index_o;
  logic [OutDsqW-1:0]        best_dist_sq_o;

  // Gate settings as last written.
  logic [DistGateW-1:0]      gate_dist;
  logic [YawW-1:0]           gate_yaw;
  logic                      gate_yaw_on;

  // Search state mirrored from the unit.
  logic signed [PosW-1:0]    query_px;
  logic signed [PosW-1:0]    query_py;
  logic [YawW-1:0]           query_heading;
  int unsigned               points_seen;
  logic                      best_valid;
  logic [OutIdxW-1:0]        best_slot;
  logic [OutDsqW-1:0]        best_sq;

  search_result_t            pending_results[$];
  int                        error_count = 0;
  int                        items_sent = 0;
  int                        stall_left = 0;
  int                        quiet_cycles = 0;
  bit                        idle_on = 1'b1;

  gated_nearest_path_point_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .yaw_i          (yaw_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .best_index_o   (best_index_o),
    .best_dist_sq_o (best_dist_sq_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Exact squared distance between two positions.
  function automatic logic [OutDsqW-1:0] squared_gap(input logic signed [PosW-1:0] ax,
                                                     input logic signed [PosW-1:0] ay,
                                                     input logic signed [PosW-1:0] bx,
                                                     input logic signed [PosW-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return OutDsqW'(dx * dx + dy * dy);
  endfunction

  // The heading difference wraps around a full turn before its magnitude is gated.
  function automatic bit heading_ok(input logic [YawW-1:0] q, input logic [YawW-1:0] p);
    logic [YawW-1:0] diff;
    int              mag;
    diff = q - p;
    mag  = diff[YawW-1] ? 65536 - int'(diff) : int'(diff);
    return mag <= int'(gate_yaw);
  endfunction

  // Loads a query and forgets the best point so far.
  task automatic clear_search(input logic signed [PosW-1:0] x, input logic signed [PosW-1:0] y,
                              input logic [YawW-1:0] w);
    query_px      = x;
    query_py      = y;
    query_heading = w;
    points_seen   = 0;
    best_valid    = 1'b0;
    best_slot     = '0;
    best_sq       = '0;
  endtask

  // Advances the mirrored search by one accepted transfer.
  task automatic track_search(input logic [1:0] op, input logic signed [PosW-1:0] x,
                              input logic signed [PosW-1:0] y, input logic [YawW-1:0] w);
    logic [OutDsqW-1:0] dsq;
    bit                 pass;
    search_result_t     res;
    case (op)
      OP_START: begin
        clear_search(x, y, w);
      end
      OP_POINT: begin
        // Points past the path length limit are dropped.
        if (points_seen < MaxPoints) begin
          dsq  = squared_gap(x, y, query_px, query_py);
          pass = longint'(dsq) <= longint'(gate_dist) * longint'(gate_dist);
          if (pass && gate_yaw_on) begin
            pass = heading_ok(query_heading, w);
          end
          if (pass && (!best_valid || dsq < best_sq)) begin
            best_valid = 1'b1;
            best_slot  = OutIdxW'(points_seen);
            best_sq    = dsq;
          end
          points_seen++;
        end
      end
      OP_FINISH: begin
        res.found = best_valid;
        res.idx   = best_valid ? best_slot : '0;
        res.dsq   = best_valid ? best_sq : '0;
        pending_results.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // Sends one item after a random gap, if gaps are on, and waits for its transfer.
  task automatic send_item(input logic [1:0] op, input logic signed [PosW-1:0] x,
                           input logic signed [PosW-1:0] y, input logic [YawW-1:0] w);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    pos_x_i    <= x;
    pos_y_i    <= y;
    yaw_i      <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_search(op, x, y, w);
    items_sent++;
  endtask

  // Holds the input channel until every pending result has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes all gate registers once the unit has gone quiet.
  task automatic program_gates(input logic [CfgDataW-1:0] dist_val,
                               input logic [CfgDataW-1:0] ang_val,
                               input logic [CfgDataW-1:0] en_val);
    wait_drained();
    // Points still in the work queue must clear before the gates change.
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DIST_GATE;
    cfg_wdata_i <= dist_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_YAW_GATE;
    cfg_wdata_i <= ang_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_ANGLE_EN;
    cfg_wdata_i <= en_val;
    @(posedge clk_i);
    // A write to the unused index must change nothing.
    cfg_index_i <= CFG_SPARE;
    cfg_wdata_i <= CfgDataW'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gate_dist   = dist_val[DistGateW-1:0];
    gate_yaw    = ang_val[YawW-1:0];
    gate_yaw_on = en_val[0];
  endtask

  function automatic logic signed [PosW-1:0] any_pos();
    return PosW'($urandom);
  endfunction

  function automatic logic signed [PosW-1:0] near_pos(input logic signed [PosW-1:0] c,
                                                      input int unsigned spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - int'(spread);
    return c + PosW'(off);
  endfunction

  function automatic logic [YawW-1:0] near_heading(input logic [YawW-1:0] c,
                                                   input int unsigned swing);
    int off;
    off = int'($urandom_range(0, 2 * swing)) - int'(swing);
    return c + YawW'(off);
  endfunction

  // One search with random content: mostly points close to the gates, with some noise.
  task automatic run_search(input int n, input bit with_start);
    logic signed [PosW-1:0] qx;
    logic signed [PosW-1:0] qy;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic [YawW-1:0]        qw;
    logic [YawW-1:0]        pw;
    int unsigned            spread;
    int unsigned            swing;
    int                     pick;
    qx = ($urandom_range(0, 3) == 0) ? any_pos() : near_pos('0, 20000);
    qy = ($urandom_range(0, 3) == 0) ? any_pos() : near_pos('0, 20000);
    qw = YawW'($urandom);
    if (with_start) begin
      send_item(OP_START, qx, qy, qw);
    end else begin
      qx = query_px;
      qy = query_py;
      qw = query_heading;
    end
    spread = gate_dist + gate_dist / 2 + 2;
    swing  = gate_yaw_on ? gate_yaw + gate_yaw / 4 + 2 : 32768;
    if (swing > 32768) begin
      swing = 32768;
    end
    px = qx;
    py = qy;
    pw = qw;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_item(OP_UNUSED, any_pos(), any_pos(), YawW'($urandom));
      end else if (pick == 1) begin
        send_item(OP_FINISH, any_pos(), any_pos(), YawW'($urandom));
      end else if (pick == 2 && i > 0) begin
        // Same point again, so the earlier index must hold the tie.
        send_item(OP_POINT, px, py, pw);
      end else begin
        if (pick == 3) begin
          px = any_pos();
          py = any_pos();
          pw = YawW'($urandom);
        end else begin
          px = near_pos(qx, spread);
          py = near_pos(qy, spread);
          pw = near_heading(qw, swing);
        end
        send_item(OP_POINT, px, py, pw);
      end
    end
    send_item(OP_FINISH, any_pos(), any_pos(), YawW'($urandom));
  endtask

  // Points sent before any start are compared with the query at the origin.
  task automatic test_before_start();
    send_item(OP_POINT, 24'sd100, -24'sd200, 16'd10);
    send_item(OP_POINT, 24'sd0, 24'sd0, 16'd8192);
    send_item(OP_POINT, 24'sd0, 24'sd0, 16'd8193);
    send_item(OP_POINT, 24'sd0, 24'sd1, 16'd57344);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);
    send_item(OP_UNUSED, -24'sd8388608, 24'sd8388607, 16'hFFFF);
    send_item(OP_FINISH, 24'sd8388607, -24'sd8388608, 16'hFFFF);
  endtask

  // Corner positions, gate boundaries, heading wrap and ties.
  task automatic test_field_extremes();
    program_gates(23'd8388607, 23'd32768, 23'd1);
    send_item(OP_START, -24'sd8388608, -24'sd8388608, 16'd0);
    send_item(OP_POINT, 24'sd8388607, 24'sd8388607, 16'd32768);
    send_item(OP_POINT, -24'sd8388608, 24'sd8388607, 16'd0);
    // Exactly on the distance gate, half a turn away in heading.
    send_item(OP_POINT, -24'sd1, -24'sd8388608, 16'd32768);
    send_item(OP_POINT, -24'sd8388608, -24'sd8388608, 16'hFFFF);
    send_item(OP_POINT, -24'sd8388608, -24'sd8388608, 16'hFFFF);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);

    // Zero gates pass only an exact match in position and heading.
    program_gates(23'd0, 23'd0, 23'd1);
    send_item(OP_START, 24'sd8388607, -24'sd8388608, 16'hFFFF);
    send_item(OP_POINT, 24'sd8388607, -24'sd8388608, 16'd0);
    send_item(OP_POINT, 24'sd8388607, -24'sd8388607, 16'hFFFF);
    send_item(OP_POINT, 24'sd8388607, -24'sd8388608, 16'hFFFF);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);

    // Heading gate off; an empty search reports nothing found.
    program_gates(23'd0, 23'd0, 23'd0);
    send_item(OP_START, 24'sd0, 24'sd0, 16'd0);
    send_item(OP_POINT, 24'sd0, 24'sd0, 16'd32768);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);
    send_item(OP_START, 24'sd5, 24'sd5, 16'd5);
    send_item(OP_FINISH, 24'sd0, 24'sd0, 16'd0);
  endtask

  // Random searches over several gate settings, the extremes among them.
  task automatic test_random_searches();
    int first_item;
    int phase_start;
    int phase;
    first_item = items_sent;
    phase      = 0;
    while (items_sent - first_item < RandomItems) begin
      case (phase % 6)
        0: program_gates(23'd1280, 23'd8192, 23'd1);
        1: program_gates(23'd0, 23'd0, 23'd1);
        2: program_gates(23'd8388607, 23'd32768, 23'd1);
        3: program_gates(CfgDataW'($urandom_range(0, 8388607)), CfgDataW'($urandom), 23'd0);
        4: program_gates(CfgDataW'($urandom_range(0, 4000)), 23'd0, 23'd1);
        default: program_gates(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
      endcase
      // One phase runs with no gaps and no stalls at all.
      idle_on     = (phase % 6) != 2;
      phase_start = items_sent;
      while (items_sent - phase_start < 75) begin
        run_search($urandom_range(0, 12), $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
        end
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // Result checker; with idle_on set the receiver stalls a random number of cycles after each transfer.
  always @(posedge clk_i) begin : check_results
    search_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no finish pending: found %0d index %0d dist_sq %0d",
                 $time, found_o, best_index_o, best_dist_sq_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found) begin
          $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found, found_o);
          error_count++;
        end
        if (best_index_o !== want.idx) begin
          $display("%0t: best_index mismatch: expected %0d, actual %0d",
                   $time, want.idx, best_index_o);
          error_count++;
        end
        if (best_dist_sq_o !== want.dsq) begin
          $display("%0t: best_dist_sq mismatch: expected %0d, actual %0d",
                   $time, want.dsq, best_dist_sq_o);
          error_count++;
        end
      end
      stall_left = idle_on ? $urandom_range(0, 4) : 0;
    end
    out_stall_i <= (stall_left > 0);
    if (stall_left > 0) begin
      stall_left--;
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    gate_dist   = DIST_GATE_RST;
    gate_yaw    = YAW_GATE_RST;
    gate_yaw_on = 1'b1;
    clear_search('0, '0, '0);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_before_start();
    test_field_extremes();
    test_random_searches();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
